// ===== rtl/fbsc_pkg.sv =====
// Shared constants for the frustum box / sphere classifier.
// Holds field widths, register indexes and result codes; no dependencies.
package fbsc_pkg;

  // Defaults for the top-level parameters.
  localparam int COORD_WIDTH_DEF = 16;
  localparam int PLANE_COUNT_DEF = 6;

  // Plane register layout: nx, ny, nz in Q1.14, offset in Q15.0.
  localparam int NUM_PLANE_REGS = 6;
  localparam int PLANE_W        = 64;
  localparam int NORM_W         = 16;
  localparam int NORM_FRAC      = 14;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd7;

  // Field widths.
  localparam int PAD_W = 15;
  localparam int TOL_W = 16;
  localparam int VIS_W = 2;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd2;

  // Result codes.
  localparam logic [VIS_W-1:0] VIS_OUTSIDE   = 2'd0;
  localparam logic [VIS_W-1:0] VIS_INTERSECT = 2'd1;
  localparam logic [VIS_W-1:0] VIS_INSIDE    = 2'd2;

endpackage

// ===== rtl/frustum_box_sphere_classifier.sv =====
// Frustum box / sphere classifier, top level.
// The result strobe is registered beside the compare stage at the end of the pipeline.
// Throughput: one transaction per cycle; busy stays low, the four register stages
// (padding, products, distances, compare) each take a new transaction every cycle.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and the registers:
// planes 0, planes disabled, tolerance 2. Depends on fbsc_pkg and fbsc_plane_lane.
module frustum_box_sphere_classifier #(
  parameter int COORD_WIDTH = fbsc_pkg::COORD_WIDTH_DEF,
  parameter int PLANE_COUNT = fbsc_pkg::PLANE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic signed [COORD_WIDTH-1:0]    in_x_lo,
  input  logic signed [COORD_WIDTH-1:0]    in_y_lo,
  input  logic signed [COORD_WIDTH-1:0]    in_z_lo,
  input  logic signed [COORD_WIDTH-1:0]    in_x_hi,
  input  logic signed [COORD_WIDTH-1:0]    in_y_hi,
  input  logic signed [COORD_WIDTH-1:0]    in_z_hi,
  input  logic [fbsc_pkg::PAD_W-1:0]       in_radius_or_pad,
  output logic                             out_strobe,
  output logic [fbsc_pkg::VIS_W-1:0]       out_visibility,
  input  logic                             cfg_we,
  input  logic [fbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbsc_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import fbsc_pkg::*;

  localparam int PW    = COORD_WIDTH + NORM_W;
  localparam int DW    = ((PW > 30) ? PW : 30) + 2;
  localparam int EW    = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam int NLANE = (PLANE_COUNT < NUM_PLANE_REGS) ? PLANE_COUNT : NUM_PLANE_REGS;

  // Configuration registers.
  logic [PLANE_W-1:0] plane_r [NUM_PLANE_REGS];
  logic               planes_ok_r;
  logic [TOL_W-1:0]   tol_r;

  // Stage 1: chosen corners and side information.
  logic                          accept;
  logic signed [COORD_WIDTH-1:0] lo_in [3];
  logic signed [COORD_WIDTH-1:0] hi_in [3];
  logic signed [COORD_WIDTH-1:0] ord_lo, ord_hi;
  logic signed [EW-1:0]          pad_ext, plo, phi;
  logic signed [COORD_WIDTH-1:0] plo_t [3];
  logic signed [COORD_WIDTH-1:0] phi_t [3];
  logic                          pad_ok;
  logic                          use_pad;
  logic                          raw_bad;
  logic signed [COORD_WIDTH-1:0] s1_lo_nxt [3];
  logic signed [COORD_WIDTH-1:0] s1_hi_nxt [3];
  logic                          s1_bad_nxt;
  logic [TOL_W-1:0]              s1_thr_nxt;

  logic                          s1_vld_r, s2_vld_r, s3_vld_r;
  logic signed [COORD_WIDTH-1:0] s1_lo_r [3];
  logic signed [COORD_WIDTH-1:0] s1_hi_r [3];
  logic                          s1_bad_r, s2_bad_r, s3_bad_r;
  logic [TOL_W-1:0]              s1_thr_r, s2_thr_r, s3_thr_r;

  // Distances from the lanes and the compare stage.
  logic signed [DW-1:0] dist_p [NLANE];
  logic signed [DW-1:0] dist_n [NLANE];
  logic signed [DW-1:0] thr_s;
  logic                 any_out, any_isect;
  logic [VIS_W-1:0]     vis_nxt;
  logic                 out_strobe_r;
  logic [VIS_W-1:0]     out_vis_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        plane_r[i] <= '0;
      end
      planes_ok_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLANE_ENABLE: planes_ok_r <= cfg_wdata[0];
        REG_TOLERANCE:    tol_r <= cfg_wdata[TOL_W-1:0];
        default: begin
          if (cfg_index < CFG_IDX_W'(NUM_PLANE_REGS)) begin
            plane_r[cfg_index] <= cfg_wdata;
          end
        end
      endcase
    end
  end

  // Padding: order each axis, grow by the pad and check the coordinate range.
  always_comb begin
    lo_in[0] = in_x_lo;
    lo_in[1] = in_y_lo;
    lo_in[2] = in_z_lo;
    hi_in[0] = in_x_hi;
    hi_in[1] = in_y_hi;
    hi_in[2] = in_z_hi;
    pad_ext  = EW'($signed({1'b0, in_radius_or_pad}));
    pad_ok   = 1'b1;
    raw_bad  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ord_lo   = (lo_in[a] <= hi_in[a]) ? lo_in[a] : hi_in[a];
      ord_hi   = (lo_in[a] <= hi_in[a]) ? hi_in[a] : lo_in[a];
      plo      = EW'(ord_lo) - pad_ext;
      phi      = EW'(ord_hi) + pad_ext;
      plo_t[a] = plo[COORD_WIDTH-1:0];
      phi_t[a] = phi[COORD_WIDTH-1:0];
      if (plo != EW'(plo_t[a]) || phi != EW'(phi_t[a])) begin
        pad_ok = 1'b0;
      end
      if (lo_in[a] > hi_in[a]) begin
        raw_bad = 1'b1;
      end
    end
    use_pad = (in_radius_or_pad != '0) && pad_ok;
    // A sphere is a box with both corners at its center and the radius as threshold.
    for (int a = 0; a < 3; a++) begin
      if (in_kind) begin
        s1_lo_nxt[a] = lo_in[a];
        s1_hi_nxt[a] = lo_in[a];
      end else if (use_pad) begin
        s1_lo_nxt[a] = plo_t[a];
        s1_hi_nxt[a] = phi_t[a];
      end else begin
        s1_lo_nxt[a] = lo_in[a];
        s1_hi_nxt[a] = hi_in[a];
      end
    end
    s1_bad_nxt = !in_kind && !use_pad && raw_bad;
    s1_thr_nxt = in_kind ? TOL_W'(in_radius_or_pad) : tol_r;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= accept;
      s2_vld_r     <= s1_vld_r;
      s3_vld_r     <= s2_vld_r;
      out_strobe_r <= s3_vld_r;
    end
  end

  // Payload that travels beside the lanes.
  always_ff @(posedge clk) begin
    s1_lo_r  <= s1_lo_nxt;
    s1_hi_r  <= s1_hi_nxt;
    s1_bad_r <= s1_bad_nxt;
    s1_thr_r <= s1_thr_nxt;
    s2_bad_r <= s1_bad_r;
    s2_thr_r <= s1_thr_r;
    s3_bad_r <= s2_bad_r;
    s3_thr_r <= s2_thr_r;
  end

  // One lane per active plane.
  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    fbsc_plane_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk    (clk),
      .plane  (plane_r[g]),
      .lo     (s1_lo_r),
      .hi     (s1_hi_r),
      .dist_p (dist_p[g]),
      .dist_n (dist_n[g])
    );
  end

  // Compare against the scaled threshold and merge the planes; disabled planes or a bad box give intersecting.
  always_comb begin
    thr_s     = DW'({s3_thr_r, {NORM_FRAC{1'b0}}});
    any_out   = 1'b0;
    any_isect = 1'b0;
    for (int i = 0; i < NLANE; i++) begin
      if (dist_p[i] < -thr_s) begin
        any_out = 1'b1;
      end
      if (dist_n[i] < thr_s) begin
        any_isect = 1'b1;
      end
    end
    if (!planes_ok_r || s3_bad_r) begin
      vis_nxt = VIS_INTERSECT;
    end else if (any_out) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (any_isect) begin
      vis_nxt = VIS_INTERSECT;
    end else begin
      vis_nxt = VIS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    out_vis_r <= vis_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_visibility = out_vis_r;

`ifndef SYNTHESIS
  // Every accepted transaction gives its result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_strobe)
    else $error("accepted transaction produced no result");

  // No result without an earlier accepted transaction.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 4))
    else $error("result without an accepted transaction");

  // Without usable planes every result is intersecting.
  a_invalid_planes: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && !planes_ok_r) |=> (out_visibility == VIS_INTERSECT))
    else $error("invalid planes gave a result other than intersecting");
`endif

endmodule

// ===== rtl/fbsc_plane_lane.sv =====
// One plane lane: p/n-vertex selection, products, then signed plane distances.
// Two register stages; depends on fbsc_pkg.
module fbsc_plane_lane #(
  parameter int COORD_WIDTH = fbsc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic [fbsc_pkg::PLANE_W-1:0]          plane,
  input  logic signed [COORD_WIDTH-1:0]         lo [3],
  input  logic signed [COORD_WIDTH-1:0]         hi [3],
  output logic signed [((COORD_WIDTH+16>30) ? COORD_WIDTH+16 : 30)+1:0] dist_p,
  output logic signed [((COORD_WIDTH+16>30) ? COORD_WIDTH+16 : 30)+1:0] dist_n
);
  import fbsc_pkg::*;

  localparam int PW = COORD_WIDTH + NORM_W;
  localparam int DW = ((PW > 30) ? PW : 30) + 2;

  logic signed [NORM_W-1:0] nrm [3];
  logic signed [COORD_WIDTH-1:0] pv [3];
  logic signed [COORD_WIDTH-1:0] nv [3];
  logic signed [PW-1:0] prod_p_r [3];
  logic signed [PW-1:0] prod_n_r [3];
  logic signed [NORM_W-1:0] off_r;
  logic signed [DW-1:0] off_term;
  logic signed [DW-1:0] dist_p_r;
  logic signed [DW-1:0] dist_n_r;

  // The p-vertex takes hi where the normal component is not negative.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm[a] = plane[a*NORM_W +: NORM_W];
      pv[a]  = nrm[a][NORM_W-1] ? lo[a] : hi[a];
      nv[a]  = nrm[a][NORM_W-1] ? hi[a] : lo[a];
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      prod_p_r[a] <= PW'(nrm[a]) * PW'(pv[a]);
      prod_n_r[a] <= PW'(nrm[a]) * PW'(nv[a]);
    end
    off_r <= plane[3*NORM_W +: NORM_W];
  end

  // Distance stage: three products plus the offset scaled to Q.14.
  assign off_term = DW'(off_r) <<< NORM_FRAC;

  always_ff @(posedge clk) begin
    dist_p_r <= DW'(prod_p_r[0]) + DW'(prod_p_r[1]) + DW'(prod_p_r[2]) + off_term;
    dist_n_r <= DW'(prod_n_r[0]) + DW'(prod_n_r[1]) + DW'(prod_n_r[2]) + off_term;
  end

  assign dist_p = dist_p_r;
  assign dist_n = dist_n_r;

endmodule

// ===== dv/tb_frustum_box_sphere_classifier.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for frustum_box_sphere_classifier: directed and random boxes and
// spheres against axis-aligned, tilted and raw plane sets. Depends on fbsc_pkg and the RTL.
module tb_frustum_box_sphere_classifier;
  import fbsc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int PLANES_USED =
    (PLANE_COUNT_DEF < NUM_PLANE_REGS) ? PLANE_COUNT_DEF : NUM_PLANE_REGS;
  localparam int LATENCY = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 40;
  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam int UNIT_NORMAL = 1 << NORM_FRAC;

  // Plane register indexes; the enable and tolerance indexes come from the package.
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT = 3'd0;

  // Volume kinds.
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_SPHERE = 1'b1;

  typedef enum logic [1:0] {SETUP_FRUSTUM, SETUP_RAW, SETUP_DISABLED} setup_kind_t;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] x_lo;
    logic [CW-1:0] y_lo;
    logic [CW-1:0] z_lo;
    logic [CW-1:0] x_hi;
    logic [CW-1:0] y_hi;
    logic [CW-1:0] z_hi;
    logic [PAD_W-1:0] pad;
  } volume_t;

  typedef struct packed {
    logic [VIS_W-1:0] vis;
    logic [31:0]      seq;
  } verdict_t;

  // Clock, reset and DUT ports.
  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_kind;
  logic signed [CW-1:0] in_x_lo, in_y_lo, in_z_lo, in_x_hi, in_y_hi, in_z_hi;
  logic [PAD_W-1:0] in_radius_or_pad;
  logic out_strobe;
  logic [VIS_W-1:0] out_visibility;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  // Predictor copy of the configuration, plus the plane set staged for the next write.
  logic [PLANE_W-1:0] frustum_planes [NUM_PLANE_REGS];
  logic [PLANE_W-1:0] next_planes [NUM_PLANE_REGS];
  logic               planes_on;
  logic [TOL_W-1:0]   box_tolerance;

  // Outstanding verdicts and run statistics.
  verdict_t pending_verdicts [$];
  verdict_t oldest;
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int seen_outside = 0;
  int seen_intersect = 0;
  int seen_inside = 0;

  frustum_box_sphere_classifier uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_x_lo          (in_x_lo),
    .in_y_lo          (in_y_lo),
    .in_z_lo          (in_z_lo),
    .in_x_hi          (in_x_hi),
    .in_y_hi          (in_y_hi),
    .in_z_hi          (in_z_hi),
    .in_radius_or_pad (in_radius_or_pad),
    .out_strobe       (out_strobe),
    .out_visibility   (out_visibility),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts outstanding", cycle_count,
               pending_verdicts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Sign-extends a coordinate field to the predictor's working width.
  function automatic longint to_coord(input logic [CW-1:0] f);
    logic signed [CW-1:0] s;
    s = f;
    return longint'(s);
  endfunction

  // One signed 16-bit part of a plane: 0 nx, 1 ny, 2 nz, 3 offset.
  function automatic longint plane_term(input int p, input int part);
    logic signed [NORM_W-1:0] raw;
    raw = frustum_planes[p][NORM_W*part +: NORM_W];
    return longint'(raw);
  endfunction

  // Exact signed plane distance, scaled by 2^14.
  function automatic longint plane_distance(input int p, input longint cx, input longint cy,
                                            input longint cz);
    return plane_term(p, 0) * cx + plane_term(p, 1) * cy + plane_term(p, 2) * cz +
           plane_term(p, 3) * (longint'(1) << NORM_FRAC);
  endfunction

  // Box against all planes with the p-vertex / n-vertex rule.
  function automatic logic [VIS_W-1:0] classify_box(input longint lx, input longint ly,
                                                    input longint lz, input longint hx,
                                                    input longint hy, input longint hz);
    longint lo [3];
    longint hi [3];
    longint pv [3];
    longint nv [3];
    longint eps;
    logic [VIS_W-1:0] verdict;
    lo[0] = lx; lo[1] = ly; lo[2] = lz;
    hi[0] = hx; hi[1] = hy; hi[2] = hz;
    eps = longint'(box_tolerance) * (longint'(1) << NORM_FRAC);
    verdict = VIS_INSIDE;
    for (int a = 0; a < 3; a++) begin
      if (lo[a] > hi[a]) return VIS_INTERSECT;
    end
    for (int p = 0; p < PLANES_USED; p++) begin
      for (int a = 0; a < 3; a++) begin
        pv[a] = (plane_term(p, a) >= 0) ? hi[a] : lo[a];
        nv[a] = (plane_term(p, a) >= 0) ? lo[a] : hi[a];
      end
      if (plane_distance(p, pv[0], pv[1], pv[2]) < -eps) return VIS_OUTSIDE;
      if (plane_distance(p, nv[0], nv[1], nv[2]) < eps) verdict = VIS_INTERSECT;
    end
    return verdict;
  endfunction

  // Sphere center distance against the scaled radius.
  function automatic logic [VIS_W-1:0] classify_sphere(input longint cx, input longint cy,
                                                       input longint cz, input longint r);
    longint rs;
    longint d;
    logic [VIS_W-1:0] verdict;
    rs = r * (longint'(1) << NORM_FRAC);
    verdict = VIS_INSIDE;
    for (int p = 0; p < PLANES_USED; p++) begin
      d = plane_distance(p, cx, cy, cz);
      if (d < -rs) return VIS_OUTSIDE;
      if (d < rs) verdict = VIS_INTERSECT;
    end
    return verdict;
  endfunction

  // Full verdict for one volume under the current configuration.
  function automatic logic [VIS_W-1:0] classify_volume(input volume_t v);
    longint lo [3];
    longint hi [3];
    longint plo [3];
    longint phi [3];
    longint pad;
    longint lesser;
    longint greater;
    logic fits;
    lo[0] = to_coord(v.x_lo); lo[1] = to_coord(v.y_lo); lo[2] = to_coord(v.z_lo);
    hi[0] = to_coord(v.x_hi); hi[1] = to_coord(v.y_hi); hi[2] = to_coord(v.z_hi);
    pad = longint'(v.pad);
    if (!planes_on) return VIS_INTERSECT;
    if (v.kind == KIND_SPHERE) return classify_sphere(lo[0], lo[1], lo[2], pad);
    if (pad == 0) return classify_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    // Padded box: order each axis, grow it, and fall back when it leaves the range.
    fits = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lesser  = (lo[a] <= hi[a]) ? lo[a] : hi[a];
      greater = (lo[a] <= hi[a]) ? hi[a] : lo[a];
      plo[a] = lesser - pad;
      phi[a] = greater + pad;
      if (plo[a] < COORD_MIN || phi[a] > COORD_MAX) fits = 1'b0;
    end
    if (fits) return classify_box(plo[0], plo[1], plo[2], phi[0], phi[1], phi[2]);
    return classify_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Saturates an integer into a coordinate field.
  function automatic logic [CW-1:0] to_field(input int x);
    int c;
    c = x;
    if (c > int'(COORD_MAX)) c = int'(COORD_MAX);
    if (c < int'(COORD_MIN)) c = int'(COORD_MIN);
    return c[CW-1:0];
  endfunction

  function automatic logic [PLANE_W-1:0] make_plane(input int nx, input int ny, input int nz,
                                                    input int off);
    return {off[NORM_W-1:0], nz[NORM_W-1:0], ny[NORM_W-1:0], nx[NORM_W-1:0]};
  endfunction

  function automatic volume_t make_box(input int lx, input int ly, input int lz, input int hx,
                                       input int hy, input int hz, input int pad);
    volume_t v;
    v.kind = KIND_BOX;
    v.x_lo = to_field(lx); v.y_lo = to_field(ly); v.z_lo = to_field(lz);
    v.x_hi = to_field(hx); v.y_hi = to_field(hy); v.z_hi = to_field(hz);
    v.pad = pad[PAD_W-1:0];
    return v;
  endfunction

  function automatic volume_t make_sphere(input int cx, input int cy, input int cz,
                                          input int r);
    volume_t v;
    v = make_box(cx, cy, cz, int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX), r);
    v.kind = KIND_SPHERE;
    return v;
  endfunction

  // Stages a six-plane box frustum with half extents per axis and random tilt.
  function automatic void stage_frustum(input int hx, input int hy, input int hz,
                                        input int tilt);
    int half [3];
    int n [3];
    int axis;
    half[0] = hx; half[1] = hy; half[2] = hz;
    for (int p = 0; p < NUM_PLANE_REGS; p++) begin
      axis = p / 2;
      for (int a = 0; a < 3; a++) n[a] = int'($urandom_range(0, 2 * tilt)) - tilt;
      n[axis] = UNIT_NORMAL - int'($urandom_range(0, tilt));
      if (p % 2 == 1) n[axis] = -n[axis];
      next_planes[p] = make_plane(n[0], n[1], n[2], half[axis]);
    end
  endfunction

  // Random volume: mostly near the frustum, the rest unconstrained noise.
  function automatic volume_t random_volume(input int span);
    volume_t v;
    logic [31:0] r [7];
    int lo [3];
    int hi [3];
    int c;
    int s;
    int t;
    for (int i = 0; i < 7; i++) r[i] = $urandom;
    if ($urandom_range(0, 99) < 25) begin
      v.kind = r[6][16];
      v.x_lo = r[0][CW-1:0]; v.y_lo = r[1][CW-1:0]; v.z_lo = r[2][CW-1:0];
      v.x_hi = r[3][CW-1:0]; v.y_hi = r[4][CW-1:0]; v.z_hi = r[5][CW-1:0];
      v.pad = ($urandom_range(0, 3) == 0) ? '0 : r[6][PAD_W-1:0];
      return v;
    end
    for (int a = 0; a < 3; a++) begin
      c = int'($urandom_range(0, 2 * span)) - span;
      s = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4000))
                                      : int'($urandom_range(0, 400));
      lo[a] = c - s / 2;
      hi[a] = c + s / 2;
      if ($urandom_range(0, 99) < 8) begin
        t = lo[a]; lo[a] = hi[a]; hi[a] = t;
      end
    end
    v = make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 0);
    if ($urandom_range(0, 2) == 0) begin
      v.kind = KIND_SPHERE;
      v.x_hi = r[3][CW-1:0]; v.y_hi = r[4][CW-1:0]; v.z_hi = r[5][CW-1:0];
      v.pad = ($urandom_range(0, 7) == 0) ? r[6][PAD_W-1:0]
                                          : PAD_W'($urandom_range(0, 2000));
    end else begin
      t = $urandom_range(0, 99);
      if (t < 50) v.pad = '0;
      else if (t < 85) v.pad = PAD_W'($urandom_range(1, 300));
      else v.pad = PAD_W'($urandom_range(1, 32767));
    end
    return v;
  endfunction

  // Counts a mismatch; only the first few are printed.
  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Sends one volume, records its verdict when accepted, then maybe idles.
  task automatic send_volume(input volume_t v);
    verdict_t e;
    start <= 1'b1;
    in_kind <= v.kind;
    in_x_lo <= v.x_lo; in_y_lo <= v.y_lo; in_z_lo <= v.z_lo;
    in_x_hi <= v.x_hi; in_y_hi <= v.y_hi; in_z_hi <= v.z_hi;
    in_radius_or_pad <= v.pad;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    e.vis = classify_volume(v);
    e.seq = items_sent;
    pending_verdicts.push_back(e);
    items_sent++;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Waits until every verdict has arrived and the pipeline has emptied.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PLANE_ENABLE: planes_on = data[0];
      REG_TOLERANCE:    box_tolerance = data[TOL_W-1:0];
      default:          frustum_planes[idx] = data;
    endcase
  endtask

  // Writes the staged planes, the enable flag and the tolerance while idle.
  // Upper bits of the narrow registers carry junk that must be ignored.
  task automatic commit_setup(input logic valid, input logic [TOL_W-1:0] tol);
    logic [CFG_DAT_W-1:0] word;
    drain_pipeline();
    for (int p = 0; p < NUM_PLANE_REGS; p++) begin
      write_register(REG_PLANE_LEFT + CFG_IDX_W'(p), next_planes[p]);
    end
    word = {$urandom, $urandom};
    word[0] = valid;
    write_register(REG_PLANE_ENABLE, word);
    word = {$urandom, $urandom};
    word[TOL_W-1:0] = tol;
    write_register(REG_TOLERANCE, word);
    cfg_we <= 1'b0;
  endtask

  // Registers at their reset values: every volume is intersecting.
  task automatic test_reset_defaults();
    send_volume(make_box(-160, -160, -160, 160, 160, 160, 0));
    send_volume(make_sphere(3000, 0, 0, 16));
  endtask

  // Boxes against an axis-aligned frustum of half extent 1600 units.
  task automatic test_box_cases();
    stage_frustum(1600, 1600, 1600, 0);
    commit_setup(1'b1, TOL_RESET);
    send_volume(make_box(-160, -160, -160, 160, 160, 160, 0));
    send_volume(make_box(2000, 0, 0, 3000, 16, 16, 0));
    send_volume(make_box(1500, 0, 0, 1700, 16, 16, 0));
    // Unpadded box with lo above hi.
    send_volume(make_box(160, 0, 0, -160, 16, 16, 0));
    // Padded box with swapped corners is ordered first.
    send_volume(make_box(160, 160, 160, -160, -160, -160, 32));
    // Padding that overflows the range falls back to the unpadded corners.
    send_volume(make_box(-160, -160, -160, 32767, 160, 160, 1));
    send_volume(make_box(100, 0, 0, -32768, 16, 16, 5));
    send_volume(make_box(-16, -16, -16, 16, 16, 16, 32767));
    send_volume(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 0));
    // Just inside and just past the tolerance band of the left plane.
    send_volume(make_box(-1700, 0, 0, -1602, 16, 16, 0));
    send_volume(make_box(-1700, 0, 0, -1603, 16, 16, 0));
  endtask

  task automatic test_sphere_cases();
    send_volume(make_sphere(0, 0, 0, 16));
    send_volume(make_sphere(3000, 0, 0, 16));
    send_volume(make_sphere(1600, 0, 0, 100));
    send_volume(make_sphere(-1600, 0, 0, 0));
    send_volume(make_sphere(0, 0, 0, 32767));
    send_volume(make_sphere(-32768, -32768, -32768, 0));
  endtask

  // Zero and maximum tolerance on the same frustum.
  task automatic test_tolerance_extremes();
    commit_setup(1'b1, '0);
    send_volume(make_box(-1700, 0, 0, -1601, 16, 16, 0));
    send_volume(make_box(-1700, 0, 0, -1600, 16, 16, 0));
    commit_setup(1'b1, '1);
    send_volume(make_box(2000, 0, 0, 3000, 16, 16, 0));
  endtask

  // Extreme normal and offset codes, then planes marked invalid.
  task automatic test_extreme_planes();
    next_planes[0] = make_plane(-32768, 32767, -32768, 32767);
    next_planes[1] = make_plane(32767, -32768, 32767, -32768);
    commit_setup(1'b1, TOL_RESET);
    send_volume(make_box(0, 0, 0, 16, 16, 16, 0));
    send_volume(make_sphere(0, 0, 0, 32767));
    stage_frustum(1600, 1600, 1600, 0);
    commit_setup(1'b0, TOL_RESET);
    send_volume(make_box(-160, -160, -160, 160, 160, 160, 0));
  endtask

  // One random phase under a fresh plane setup.
  task automatic test_random_phase(input setup_kind_t setup, input int tol, input int count);
    if (setup == SETUP_RAW) begin
      for (int p = 0; p < NUM_PLANE_REGS; p++) next_planes[p] = {$urandom, $urandom};
    end else begin
      stage_frustum($urandom_range(400, 6000), $urandom_range(400, 6000),
                    $urandom_range(400, 6000), $urandom_range(0, 3000));
    end
    commit_setup(setup != SETUP_DISABLED, tol[TOL_W-1:0]);
    for (int i = 0; i < count; i++) send_volume(random_volume(9000));
  endtask

  // Result checker: every strobe is matched against the oldest outstanding verdict.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("visibility %0d with no transaction outstanding",
                                  out_visibility));
      end else begin
        oldest = pending_verdicts.pop_front();
        results_checked++;
        if (out_visibility !== oldest.vis) begin
          report_mismatch($sformatf("transaction %0d: visibility %0d, expected %0d",
                                    oldest.seq, out_visibility, oldest.vis));
        end
        case (oldest.vis)
          VIS_OUTSIDE:   seen_outside++;
          VIS_INTERSECT: seen_intersect++;
          default:       seen_inside++;
        endcase
      end
    end
  end

  // Test sequence.
  initial begin
    for (int p = 0; p < NUM_PLANE_REGS; p++) frustum_planes[p] = '0;
    planes_on = 1'b0;
    box_tolerance = TOL_RESET;
    start <= 1'b0;
    in_kind <= KIND_BOX;
    in_x_lo <= '0; in_y_lo <= '0; in_z_lo <= '0;
    in_x_hi <= '0; in_y_hi <= '0; in_z_hi <= '0;
    in_radius_or_pad <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 36;
    test_reset_defaults();
    test_box_cases();
    test_sphere_cases();
    test_tolerance_extremes();
    test_extreme_planes();

    test_random_phase(SETUP_FRUSTUM, $urandom_range(0, 40), 150);
    test_random_phase(SETUP_RAW, $urandom_range(0, 65535), 50);
    sender_idle_pct = 58;
    test_random_phase(SETUP_FRUSTUM, 0, 150);
    test_random_phase(SETUP_FRUSTUM, 65535, 40);
    sender_idle_pct = 0;
    test_random_phase(SETUP_FRUSTUM, $urandom_range(0, 40), 130);
    test_random_phase(SETUP_DISABLED, $urandom_range(0, 40), 30);
    drain_pipeline();

    $display("Checked %0d verdicts from %0d transactions over directed, frustum and raw planes.",
             results_checked, items_sent);
    $display("Expected verdicts: %0d outside, %0d intersecting, %0d inside; %0d mismatches.",
             seen_outside, seen_intersect, seen_inside, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fbsc_pkg.sv
rtl/fbsc_plane_lane.sv
rtl/frustum_box_sphere_classifier.sv
dv/tb_frustum_box_sphere_classifier.sv
